FILE: design/mtel_pkg.sv
// ----------------------------------------------------------------------------
// mtel_pkg
// Shared types, constants and helpers of the multitrack event loop store.
// ----------------------------------------------------------------------------
package mtel_pkg;

  localparam int POOL_DEPTH  = 1024;
  localparam int POOL_AW     = $clog2(POOL_DEPTH);
  localparam int LINK_W      = POOL_AW + 1;
  localparam int TRACK_COUNT = 4;
  localparam int TRACK_AW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int TIME_W      = 48;
  localparam int AT_W        = 32;
  localparam int USED_W      = 11;
  localparam int OVF_W       = 16;
  localparam int LIMIT_W     = 6;
  localparam int DIV_STEPS   = TIME_W;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  localparam logic [LINK_W-1:0]  NIL       = LINK_W'(POOL_DEPTH);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(56);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_SETLEN = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_OK   = 2'd0,
    KIND_REJ  = 2'd1,
    KIND_PLAY = 2'd2,
    KIND_REL  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_EXEC, S_ALLOC, S_INS_NIL, S_WALK_RD, S_WALK_NL, S_WALK_AT,
    S_LINK_A, S_LINK_B, S_CLR_CHK, S_CLR_WR, S_STOP, S_STOP_NX, S_TK_CHK,
    S_TK_DIV, S_TK_DIVW, S_PL_CHK, S_PL_GOT, S_TK_END, S_TK_NEXT, S_EMIT
  } eng_state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [1:0]        track;
    logic [AT_W-1:0]   at;
    logic [7:0]        status;
    logic [6:0]        data1;
    logic [6:0]        data2;
    logic [AT_W-1:0]   len;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [AT_W-1:0] at;
    logic [7:0]      st;
    logic [6:0]      d1;
    logic [6:0]      d2;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        trk;
    logic [AT_W-1:0]   at;
    logic [7:0]        st;
    logic [6:0]        d1;
    logic [6:0]        d2;
    logic [USED_W-1:0] used;
    logic [OVF_W-1:0]  ovf;
    logic              last;
  } result_t;

  function automatic logic ok_slot(input logic [LINK_W-1:0] s);
    return s < NIL;
  endfunction

endpackage

FILE: design/mtel_cmd_q.sv
// ----------------------------------------------------------------------------
// mtel_cmd_q
// Front end: two-entry command queue ahead of the command engine.
// ----------------------------------------------------------------------------
module mtel_cmd_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtel_pkg::item_t     item_in,
  output logic                full,
  input  logic                pop,
  output mtel_pkg::item_t     item_out,
  output logic                empty
);

  mtel_pkg::item_t slot_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign item_out = slot_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= item_in;
    end
  end

endmodule

FILE: design/mtel_res_q.sv
// ----------------------------------------------------------------------------
// mtel_res_q
// Four-entry result queue between the command engine and the result port.
// ----------------------------------------------------------------------------
module mtel_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtel_pkg::result_t   res_in,
  output logic                full,
  input  logic                pop,
  output mtel_pkg::result_t   res_out,
  output logic                empty
);

  mtel_pkg::result_t slot_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign res_out = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 2'd1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 2'd1 : rd_r;
    cnt_nxt = cnt_r + {2'b0, do_push} - {2'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= res_in;
    end
  end

endmodule

FILE: design/mtel_div.sv
// ----------------------------------------------------------------------------
// mtel_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mtel_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [mtel_pkg::TIME_W-1:0]         dividend,
  input  logic [mtel_pkg::AT_W-1:0]           divisor,
  output logic                                done,
  output logic [mtel_pkg::AT_W-1:0]           rem
);

  logic                              run_r, run_nxt, done_r, done_nxt;
  logic [mtel_pkg::DIV_CW-1:0]       cnt_r, cnt_nxt;
  logic [mtel_pkg::TIME_W-1:0]       q_r, q_nxt;
  logic [mtel_pkg::AT_W:0]           r_r, r_nxt, trial;
  logic [mtel_pkg::AT_W-1:0]         d_r, d_nxt;

  assign done = done_r;
  assign rem  = r_r[mtel_pkg::AT_W-1:0];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    trial    = {r_r[mtel_pkg::AT_W-1:0], q_r[mtel_pkg::TIME_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = mtel_pkg::DIV_CW'(mtel_pkg::DIV_STEPS - 1);
      q_nxt   = dividend;
      r_nxt   = '0;
      d_nxt   = divisor;
    end else if (run_r) begin
      r_nxt = (trial >= {1'b0, d_r}) ? trial - {1'b0, d_r} : trial;
      q_nxt = {q_r[mtel_pkg::TIME_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
  end

endmodule

FILE: design/mtel_engine.sv
// ----------------------------------------------------------------------------
// mtel_engine
// Back end: event pool, link memory, track lists and the command sequencer.
// ----------------------------------------------------------------------------
module mtel_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [mtel_pkg::LIMIT_W-1:0]       cfg_limit,
  input  logic                               cmd_empty,
  input  mtel_pkg::item_t                    cmd_item,
  output logic                               cmd_pop,
  output logic                               init_busy,
  input  logic                               res_full,
  output logic                               res_push,
  output mtel_pkg::result_t                  res_item
);

  localparam int TC = mtel_pkg::TRACK_COUNT;
  localparam int LW = mtel_pkg::LINK_W;
  localparam int AW = mtel_pkg::POOL_AW;
  localparam int TW = mtel_pkg::TIME_W;
  localparam int AT = mtel_pkg::AT_W;
  localparam int XW = mtel_pkg::TRACK_AW;

  // memories
  logic [LW-1:0]     nl_mem [mtel_pkg::POOL_DEPTH];
  mtel_pkg::entry_t  es_mem [mtel_pkg::POOL_DEPTH];
  logic              nl_we, es_we;
  logic [AW-1:0]     nl_wa, nl_ra, es_wa, es_ra;
  logic [LW-1:0]     nl_wd, nl_q;
  mtel_pkg::entry_t  es_wd, es_q;

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    nl_q <= nl_mem[nl_ra];
  end

  always_ff @(posedge clk) begin
    if (es_we) begin
      es_mem[es_wa] <= es_wd;
    end
    es_q <= es_mem[es_ra];
  end

  // state
  mtel_pkg::eng_state_t state_r, state_nxt, ret_r, ret_nxt;
  mtel_pkg::result_t    res_r, res_nxt;
  mtel_pkg::item_t      cmd_r, cmd_nxt;
  logic [AW-1:0]        init_r, init_nxt;
  logic [LW-1:0]        free_r, free_nxt;
  logic [mtel_pkg::USED_W-1:0] used_r, used_nxt;
  logic [mtel_pkg::OVF_W-1:0]  ovf_r, ovf_nxt;
  logic [LW-1:0]        head_r [TC], head_nxt [TC];
  logic [LW-1:0]        tail_r [TC], tail_nxt [TC];
  logic [LW-1:0]        cur_r  [TC], cur_nxt  [TC];
  logic [AT-1:0]        hat_r  [TC], hat_nxt  [TC];
  logic [AT-1:0]        tat_r  [TC], tat_nxt  [TC];
  logic [mtel_pkg::USED_W-1:0] cnt_r [TC], cnt_nxt [TC];
  logic [AT-1:0]        len_r  [TC], len_nxt  [TC];
  logic [TW-1:0]        cs_r   [TC], cs_nxt   [TC];
  logic                 play_r, play_nxt;
  logic [LW-1:0]        slot_r, slot_nxt, prev_r, prev_nxt, nx_r, nx_nxt;
  logic [XW-1:0]        ti_r, ti_nxt;
  logic [mtel_pkg::LIMIT_W-1:0] done_r, done_nxt, lim_r, lim_nxt;
  logic [AT-1:0]        el_r, el_nxt;

  logic          div_start, div_done;
  logic [AT-1:0] div_rem;
  logic [TW-1:0] diff;
  logic          trk_ok, any_events;

  mtel_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (len_r[ti_r]),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign init_busy = (state_r == mtel_pkg::S_INIT);

  function automatic mtel_pkg::result_t mk(input mtel_pkg::kind_t k,
                                           input logic [1:0] t,
                                           input mtel_pkg::entry_t e,
                                           input logic l);
    mtel_pkg::result_t r;
    r      = '0;
    r.kind = k;
    r.trk  = t;
    r.at   = e.at;
    r.st   = e.st;
    r.d1   = e.d1;
    r.d2   = e.d2;
    r.last = l;
    return r;
  endfunction

  always_comb begin
    mtel_pkg::entry_t ein;
    ein        = '{at: cmd_r.at, st: cmd_r.status, d1: cmd_r.data1, d2: cmd_r.data2};
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    res_nxt    = res_r;
    cmd_nxt    = cmd_r;
    init_nxt   = init_r;
    free_nxt   = free_r;
    used_nxt   = used_r;
    ovf_nxt    = ovf_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    hat_nxt    = hat_r;
    tat_nxt    = tat_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    cs_nxt     = cs_r;
    play_nxt   = play_r;
    slot_nxt   = slot_r;
    prev_nxt   = prev_r;
    nx_nxt     = nx_r;
    ti_nxt     = ti_r;
    done_nxt   = done_r;
    lim_nxt    = lim_r;
    el_nxt     = el_r;
    nl_we      = 1'b0;
    nl_wa      = '0;
    nl_wd      = '0;
    nl_ra      = '0;
    es_we      = 1'b0;
    es_wa      = '0;
    es_wd      = ein;
    es_ra      = '0;
    div_start  = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_item   = res_r;
    res_item.used = used_r;
    res_item.ovf  = ovf_r;
    diff       = cmd_r.now - cs_r[ti_r];
    trk_ok     = (int'(cmd_r.track) < TC);
    any_events = 1'b0;
    for (int i = 0; i < TC; i++) begin
      if (cnt_r[i] != '0) any_events = 1'b1;
    end

    case (state_r)
      mtel_pkg::S_INIT: begin
        // link every slot to the next one, the last to none
        nl_we = 1'b1;
        nl_wa = init_r;
        nl_wd = LW'(init_r) + 1'b1;
        if (init_r == AW'(mtel_pkg::POOL_DEPTH - 1)) begin
          state_nxt = mtel_pkg::S_IDLE;
        end else begin
          init_nxt = init_r + 1'b1;
        end
      end

      mtel_pkg::S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_item;
          ti_nxt    = XW'(cmd_item.track);
          state_nxt = mtel_pkg::S_EXEC;
        end
      end

      mtel_pkg::S_EXEC: begin
        ret_nxt   = mtel_pkg::S_IDLE;
        state_nxt = mtel_pkg::S_EMIT;
        res_nxt   = mk(mtel_pkg::KIND_REJ, 2'd0, '0, 1'b1);
        case (cmd_r.cmd)
          mtel_pkg::CMD_INSERT: begin
            if (trk_ok) begin
              if (!mtel_pkg::ok_slot(free_r)) begin
                if (ovf_r != '1) ovf_nxt = ovf_r + 1'b1;
              end else begin
                slot_nxt  = free_r;
                nl_ra     = free_r[AW-1:0];
                state_nxt = mtel_pkg::S_ALLOC;
              end
            end
          end
          mtel_pkg::CMD_CLEAR: begin
            if (trk_ok) begin
              slot_nxt  = head_r[ti_r];
              state_nxt = mtel_pkg::S_CLR_CHK;
            end
          end
          mtel_pkg::CMD_SETLEN: begin
            if (trk_ok && cmd_r.len != '0) begin
              len_nxt[ti_r] = cmd_r.len;
              cs_nxt[ti_r]  = cmd_r.now;
              cur_nxt[ti_r] = head_r[ti_r];
              res_nxt.kind  = mtel_pkg::KIND_OK;
            end
          end
          mtel_pkg::CMD_START: begin
            if (any_events) begin
              play_nxt = 1'b1;
              for (int i = 0; i < TC; i++) begin
                cs_nxt[i]  = cmd_r.now;
                cur_nxt[i] = head_r[i];
              end
              res_nxt.kind = mtel_pkg::KIND_OK;
            end
          end
          mtel_pkg::CMD_STOP: begin
            ti_nxt    = '0;
            state_nxt = mtel_pkg::S_STOP;
          end
          mtel_pkg::CMD_TICK: begin
            res_nxt.kind = mtel_pkg::KIND_OK;
            if (play_r) begin
              lim_nxt   = (cfg_limit > mtel_pkg::LIMIT_CAP) ? mtel_pkg::LIMIT_CAP : cfg_limit;
              done_nxt  = '0;
              ti_nxt    = '0;
              state_nxt = mtel_pkg::S_TK_CHK;
            end
          end
          default: ;
        endcase
      end

      mtel_pkg::S_ALLOC: begin
        free_nxt      = nl_q;
        used_nxt      = used_r + 1'b1;
        cnt_nxt[ti_r] = cnt_r[ti_r] + 1'b1;
        es_we         = 1'b1;
        es_wa         = slot_r[AW-1:0];
        nl_we         = 1'b1;
        nl_wa         = slot_r[AW-1:0];
        nl_wd         = mtel_pkg::NIL;
        res_nxt       = mk(mtel_pkg::KIND_OK, 2'd0, '0, 1'b1);
        ret_nxt       = mtel_pkg::S_IDLE;
        state_nxt     = mtel_pkg::S_EMIT;
        if (!mtel_pkg::ok_slot(head_r[ti_r])) begin
          head_nxt[ti_r] = slot_r;
          tail_nxt[ti_r] = slot_r;
          hat_nxt[ti_r]  = cmd_r.at;
          tat_nxt[ti_r]  = cmd_r.at;
        end else if (tat_r[ti_r] <= cmd_r.at) begin
          // append: relink old tail, then terminate the new slot
          nl_wa          = tail_r[ti_r][AW-1:0];
          nl_wd          = slot_r;
          tail_nxt[ti_r] = slot_r;
          tat_nxt[ti_r]  = cmd_r.at;
          state_nxt      = mtel_pkg::S_INS_NIL;
        end else if (cmd_r.at < hat_r[ti_r]) begin
          nl_wd          = head_r[ti_r];
          head_nxt[ti_r] = slot_r;
          hat_nxt[ti_r]  = cmd_r.at;
        end else begin
          prev_nxt  = head_r[ti_r];
          state_nxt = mtel_pkg::S_WALK_RD;
        end
      end

      mtel_pkg::S_INS_NIL: begin
        nl_we     = 1'b1;
        nl_wa     = slot_r[AW-1:0];
        nl_wd     = mtel_pkg::NIL;
        state_nxt = mtel_pkg::S_EMIT;
      end

      mtel_pkg::S_WALK_RD: begin
        nl_ra     = prev_r[AW-1:0];
        state_nxt = mtel_pkg::S_WALK_NL;
      end

      mtel_pkg::S_WALK_NL: begin
        nx_nxt = nl_q;
        if (!mtel_pkg::ok_slot(nl_q)) begin
          state_nxt = mtel_pkg::S_LINK_A;
        end else begin
          es_ra     = nl_q[AW-1:0];
          state_nxt = mtel_pkg::S_WALK_AT;
        end
      end

      mtel_pkg::S_WALK_AT: begin
        // equal times stay in arrival order: step past them
        if (es_q.at <= cmd_r.at) begin
          prev_nxt  = nx_r;
          nl_ra     = nx_r[AW-1:0];
          state_nxt = mtel_pkg::S_WALK_NL;
        end else begin
          state_nxt = mtel_pkg::S_LINK_A;
        end
      end

      mtel_pkg::S_LINK_A: begin
        nl_we = 1'b1;
        nl_wa = slot_r[AW-1:0];
        nl_wd = nx_r;
        if (!mtel_pkg::ok_slot(nx_r)) begin
          tail_nxt[ti_r] = slot_r;
          tat_nxt[ti_r]  = cmd_r.at;
        end
        state_nxt = mtel_pkg::S_LINK_B;
      end

      mtel_pkg::S_LINK_B: begin
        nl_we     = 1'b1;
        nl_wa     = prev_r[AW-1:0];
        nl_wd     = slot_r;
        state_nxt = mtel_pkg::S_EMIT;
      end

      mtel_pkg::S_CLR_CHK: begin
        if (mtel_pkg::ok_slot(slot_r)) begin
          nl_ra     = slot_r[AW-1:0];
          state_nxt = mtel_pkg::S_CLR_WR;
        end else begin
          head_nxt[ti_r] = mtel_pkg::NIL;
          tail_nxt[ti_r] = mtel_pkg::NIL;
          cur_nxt[ti_r]  = mtel_pkg::NIL;
          cnt_nxt[ti_r]  = '0;
          len_nxt[ti_r]  = '0;
          cs_nxt[ti_r]   = '0;
          res_nxt        = mk(mtel_pkg::KIND_OK, 2'd0, '0, 1'b1);
          ret_nxt        = mtel_pkg::S_IDLE;
          state_nxt      = mtel_pkg::S_EMIT;
        end
      end

      mtel_pkg::S_CLR_WR: begin
        nl_we     = 1'b1;
        nl_wa     = slot_r[AW-1:0];
        nl_wd     = free_r;
        free_nxt  = slot_r;
        if (used_r != '0) used_nxt = used_r - 1'b1;
        slot_nxt  = nl_q;
        state_nxt = mtel_pkg::S_CLR_CHK;
      end

      mtel_pkg::S_STOP: begin
        res_nxt   = mk(mtel_pkg::KIND_REL, 2'(ti_r), '0, 1'b0);
        ret_nxt   = mtel_pkg::S_STOP_NX;
        state_nxt = mtel_pkg::S_EMIT;
      end

      mtel_pkg::S_STOP_NX: begin
        cur_nxt[ti_r] = head_r[ti_r];
        if (ti_r == XW'(TC - 1)) begin
          play_nxt  = 1'b0;
          res_nxt   = mk(mtel_pkg::KIND_OK, 2'd0, '0, 1'b1);
          ret_nxt   = mtel_pkg::S_IDLE;
          state_nxt = mtel_pkg::S_EMIT;
        end else begin
          ti_nxt    = ti_r + 1'b1;
          state_nxt = mtel_pkg::S_STOP;
        end
      end

      mtel_pkg::S_TK_CHK: begin
        if (cnt_r[ti_r] == '0 || len_r[ti_r] == '0) begin
          state_nxt = mtel_pkg::S_TK_NEXT;
        end else if (diff >= TW'(len_r[ti_r])) begin
          res_nxt   = mk(mtel_pkg::KIND_REL, 2'(ti_r), '0, 1'b0);
          ret_nxt   = mtel_pkg::S_TK_DIV;
          state_nxt = mtel_pkg::S_EMIT;
        end else begin
          el_nxt    = diff[AT-1:0];
          state_nxt = mtel_pkg::S_PL_CHK;
        end
      end

      mtel_pkg::S_TK_DIV: begin
        div_start = 1'b1;
        state_nxt = mtel_pkg::S_TK_DIVW;
      end

      mtel_pkg::S_TK_DIVW: begin
        // new cycle start is now less the remainder of the elapsed time
        if (div_done) begin
          cs_nxt[ti_r]  = cmd_r.now - TW'(div_rem);
          cur_nxt[ti_r] = head_r[ti_r];
          el_nxt        = div_rem;
          state_nxt     = mtel_pkg::S_PL_CHK;
        end
      end

      mtel_pkg::S_PL_CHK: begin
        if (mtel_pkg::ok_slot(cur_r[ti_r]) && done_r < lim_r) begin
          es_ra     = cur_r[ti_r][AW-1:0];
          nl_ra     = cur_r[ti_r][AW-1:0];
          state_nxt = mtel_pkg::S_PL_GOT;
        end else begin
          state_nxt = mtel_pkg::S_TK_END;
        end
      end

      mtel_pkg::S_PL_GOT: begin
        if (es_q.at > el_r) begin
          state_nxt = mtel_pkg::S_TK_END;
        end else begin
          res_nxt       = mk(mtel_pkg::KIND_PLAY, 2'(ti_r), es_q, 1'b0);
          cur_nxt[ti_r] = nl_q;
          done_nxt      = done_r + 1'b1;
          ret_nxt       = mtel_pkg::S_PL_CHK;
          state_nxt     = mtel_pkg::S_EMIT;
        end
      end

      mtel_pkg::S_TK_END: begin
        if (done_r >= lim_r) begin
          res_nxt   = mk(mtel_pkg::KIND_OK, 2'd0, '0, 1'b1);
          ret_nxt   = mtel_pkg::S_IDLE;
          state_nxt = mtel_pkg::S_EMIT;
        end else begin
          state_nxt = mtel_pkg::S_TK_NEXT;
        end
      end

      mtel_pkg::S_TK_NEXT: begin
        if (ti_r == XW'(TC - 1)) begin
          res_nxt   = mk(mtel_pkg::KIND_OK, 2'd0, '0, 1'b1);
          ret_nxt   = mtel_pkg::S_IDLE;
          state_nxt = mtel_pkg::S_EMIT;
        end else begin
          ti_nxt    = ti_r + 1'b1;
          state_nxt = mtel_pkg::S_TK_CHK;
        end
      end

      mtel_pkg::S_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ret_r;
        end
      end

      default: state_nxt = mtel_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtel_pkg::S_INIT;
      init_r  <= '0;
      free_r  <= '0;
      used_r  <= '0;
      ovf_r   <= '0;
      play_r  <= 1'b0;
      for (int i = 0; i < TC; i++) begin
        head_r[i] <= mtel_pkg::NIL;
        tail_r[i] <= mtel_pkg::NIL;
        cur_r[i]  <= mtel_pkg::NIL;
        cnt_r[i]  <= '0;
        len_r[i]  <= '0;
        cs_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
      ovf_r   <= ovf_nxt;
      play_r  <= play_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      cs_r    <= cs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    res_r  <= res_nxt;
    cmd_r  <= cmd_nxt;
    hat_r  <= hat_nxt;
    tat_r  <= tat_nxt;
    slot_r <= slot_nxt;
    prev_r <= prev_nxt;
    nx_r   <= nx_nxt;
    ti_r   <= ti_nxt;
    done_r <= done_nxt;
    lim_r  <= lim_nxt;
    el_r   <= el_nxt;
  end

endmodule

FILE: design/multitrack_event_loop_store.sv
// ----------------------------------------------------------------------------
// multitrack_event_loop_store
// Time-sorted per-track MIDI event lists in a shared 1024-slot pool.
// ----------------------------------------------------------------------------
// After reset the block links the 1024 pool slots into its free list and holds
// in_full high meanwhile; configuration writes are taken throughout. Commands
// then run one at a time: clear walks a track list slot by slot, as does an
// insert that lands inside a list; stop gives one release result per track; a
// tick plays events and, for each track whose loop wraps, runs the remainder
// unit, which takes one bit of the 48-bit elapsed time a cycle. Results queue
// four deep.
module multitrack_event_loop_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_track,
  input  logic [31:0] in_event_time_us,
  input  logic [7:0]  in_status,
  input  logic [6:0]  in_data1,
  input  logic [6:0]  in_data2,
  input  logic [31:0] in_length_us,
  input  logic [47:0] in_now_us,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_track,
  output logic [31:0] out_time_us,
  output logic [7:0]  out_status,
  output logic [6:0]  out_data1,
  output logic [6:0]  out_data2,
  output logic [10:0] out_events_in_use,
  output logic [15:0] out_overflows,
  output logic        out_last
);

  logic [mtel_pkg::LIMIT_W-1:0] limit_r;
  mtel_pkg::item_t   in_item, cq_item;
  mtel_pkg::result_t res_item, rq_item;
  logic cq_full, cq_empty, cq_pop, init_busy, res_push, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mtel_pkg::LIMIT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign in_item = '{cmd: in_cmd, track: in_track, at: in_event_time_us,
                     status: in_status, data1: in_data1, data2: in_data2,
                     len: in_length_us, now: in_now_us};
  assign in_full = cq_full || init_busy;

  mtel_cmd_q u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push && !init_busy),
    .item_in  (in_item),
    .full     (cq_full),
    .pop      (cq_pop),
    .item_out (cq_item),
    .empty    (cq_empty)
  );

  mtel_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_limit (limit_r),
    .cmd_empty (cq_empty),
    .cmd_item  (cq_item),
    .cmd_pop   (cq_pop),
    .init_busy (init_busy),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  mtel_res_q u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .res_in  (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .res_out (rq_item),
    .empty   (out_empty)
  );

  assign out_kind          = rq_item.kind;
  assign out_track         = rq_item.trk;
  assign out_time_us       = rq_item.at;
  assign out_status        = rq_item.st;
  assign out_data1         = rq_item.d1;
  assign out_data2         = rq_item.d2;
  assign out_events_in_use = rq_item.used;
  assign out_overflows     = rq_item.ovf;
  assign out_last          = rq_item.last;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_init_blocks: assert property (@(posedge clk)
    !rst_n |=> in_full) else $error("input taken during pool linking");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_events_in_use <= 11'(mtel_pkg::POOL_DEPTH))
    else $error("slot count beyond pool depth");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty && !init_busy) else $error("command taken while busy");

endmodule

FILE: tb/tb_multitrack_event_loop_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multitrack_event_loop_store
// Self-checking bench: drives commands through the input queue, predicts every
// result transaction (plays, releases, done/rejected) and compares in order.
// ----------------------------------------------------------------------------
module tb_multitrack_event_loop_store;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_cmd = '0;
  logic [1:0]  in_track = '0;
  logic [31:0] in_event_time_us = '0;
  logic [7:0]  in_status = '0;
  logic [6:0]  in_data1 = '0;
  logic [6:0]  in_data2 = '0;
  logic [31:0] in_length_us = '0;
  logic [47:0] in_now_us = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_track;
  logic [31:0] out_time_us;
  logic [7:0]  out_status;
  logic [6:0]  out_data1;
  logic [6:0]  out_data2;
  logic [10:0] out_events_in_use;
  logic [15:0] out_overflows;
  logic        out_last;

  multitrack_event_loop_store dut (.*);

  always #4 clk = ~clk;

  // mirror of the block state
  mtel_pkg::entry_t                pool_entry [mtel_pkg::POOL_DEPTH];
  logic [mtel_pkg::LINK_W-1:0]     pool_link  [mtel_pkg::POOL_DEPTH];
  logic [mtel_pkg::LINK_W-1:0]     free_ptr;
  logic [mtel_pkg::USED_W-1:0]     slots_used;
  logic [mtel_pkg::OVF_W-1:0]      ovf_count;
  logic [mtel_pkg::LINK_W-1:0]     trk_head [mtel_pkg::TRACK_COUNT];
  logic [mtel_pkg::LINK_W-1:0]     trk_tail [mtel_pkg::TRACK_COUNT];
  logic [mtel_pkg::USED_W-1:0]     trk_count [mtel_pkg::TRACK_COUNT];
  logic [mtel_pkg::LINK_W-1:0]     trk_cursor [mtel_pkg::TRACK_COUNT];
  logic [mtel_pkg::AT_W-1:0]       trk_len [mtel_pkg::TRACK_COUNT];
  logic [mtel_pkg::TIME_W-1:0]     trk_start [mtel_pkg::TRACK_COUNT];
  logic                            is_playing;
  logic [5:0]                      tick_limit;

  mtel_pkg::result_t expected_results [$];
  int  fail_count = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  plays_seen = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  function automatic bit slot_ok(logic [mtel_pkg::LINK_W-1:0] s);
    return s < mtel_pkg::NIL;
  endfunction

  task automatic queue_result(mtel_pkg::kind_t k, int trk, mtel_pkg::entry_t e);
    mtel_pkg::result_t r;
    r.kind = k; r.trk = trk[1:0]; r.at = e.at; r.st = e.st; r.d1 = e.d1; r.d2 = e.d2;
    r.used = slots_used; r.ovf = ovf_count; r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic reset_mirror();
    for (int i = 0; i < mtel_pkg::POOL_DEPTH; i++) begin
      pool_entry[i] = '0;
      pool_link[i] = mtel_pkg::LINK_W'(i + 1);
    end
    free_ptr = '0; slots_used = '0; ovf_count = '0; is_playing = 1'b0; tick_limit = 6'd16;
    for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++) begin
      trk_head[t] = mtel_pkg::NIL; trk_tail[t] = mtel_pkg::NIL; trk_cursor[t] = mtel_pkg::NIL;
      trk_count[t] = '0; trk_len[t] = '0; trk_start[t] = '0;
    end
  endtask

  function automatic bit insert_event(int t, mtel_pkg::entry_t e);
    logic [mtel_pkg::LINK_W-1:0] s, p;
    s = free_ptr;
    if (!slot_ok(s)) begin
      if (ovf_count != 16'hFFFF) ovf_count++;
      return 0;
    end
    free_ptr = pool_link[s[mtel_pkg::POOL_AW-1:0]];
    pool_link[s[mtel_pkg::POOL_AW-1:0]] = mtel_pkg::NIL;
    slots_used++;
    pool_entry[s[mtel_pkg::POOL_AW-1:0]] = e;
    if (!slot_ok(trk_head[t])) begin
      trk_head[t] = s; trk_tail[t] = s;
    end else if (pool_entry[trk_tail[t][mtel_pkg::POOL_AW-1:0]].at <= e.at) begin
      pool_link[trk_tail[t][mtel_pkg::POOL_AW-1:0]] = s; trk_tail[t] = s;
    end else if (e.at < pool_entry[trk_head[t][mtel_pkg::POOL_AW-1:0]].at) begin
      pool_link[s[mtel_pkg::POOL_AW-1:0]] = trk_head[t]; trk_head[t] = s;
    end else begin
      p = trk_head[t];
      while (slot_ok(pool_link[p[mtel_pkg::POOL_AW-1:0]]) &&
             pool_entry[pool_link[p[mtel_pkg::POOL_AW-1:0]][mtel_pkg::POOL_AW-1:0]].at
             <= e.at)
        p = pool_link[p[mtel_pkg::POOL_AW-1:0]];
      pool_link[s[mtel_pkg::POOL_AW-1:0]] = pool_link[p[mtel_pkg::POOL_AW-1:0]];
      pool_link[p[mtel_pkg::POOL_AW-1:0]] = s;
      if (!slot_ok(pool_link[s[mtel_pkg::POOL_AW-1:0]])) trk_tail[t] = s;
    end
    trk_count[t]++;
    return 1;
  endfunction

  task automatic clear_track(int t);
    logic [mtel_pkg::LINK_W-1:0] s, nx;
    s = trk_head[t];
    while (slot_ok(s)) begin
      nx = pool_link[s[mtel_pkg::POOL_AW-1:0]];
      pool_entry[s[mtel_pkg::POOL_AW-1:0]] = '0;
      pool_link[s[mtel_pkg::POOL_AW-1:0]] = free_ptr;
      free_ptr = s;
      if (slots_used > 0) slots_used--;
      s = nx;
    end
    trk_head[t] = mtel_pkg::NIL; trk_tail[t] = mtel_pkg::NIL; trk_cursor[t] = mtel_pkg::NIL;
    trk_count[t] = '0; trk_len[t] = '0; trk_start[t] = '0;
  endtask

  task automatic run_tick(logic [mtel_pkg::TIME_W-1:0] now);
    int unsigned lim, played;
    logic [mtel_pkg::TIME_W-1:0] diff;
    mtel_pkg::entry_t e;
    lim = (tick_limit > 56) ? 56 : tick_limit;
    played = 0;
    for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++) begin
      if (trk_count[t] == 0 || trk_len[t] == 0) continue;
      diff = now - trk_start[t];
      if (diff >= trk_len[t]) begin
        queue_result(mtel_pkg::KIND_REL, t, '0);
        trk_start[t] = trk_start[t] + (diff / trk_len[t]) * trk_len[t];
        trk_cursor[t] = trk_head[t];
        diff = now - trk_start[t];
      end
      while (slot_ok(trk_cursor[t]) && played < lim) begin
        e = pool_entry[trk_cursor[t][mtel_pkg::POOL_AW-1:0]];
        if (e.at > diff[31:0]) break;
        queue_result(mtel_pkg::KIND_PLAY, t, e);
        trk_cursor[t] = pool_link[trk_cursor[t][mtel_pkg::POOL_AW-1:0]];
        played++;
      end
      if (played >= lim) break;
    end
  endtask

  task automatic predict_command(mtel_pkg::item_t it);
    bit good;
    mtel_pkg::entry_t e;
    good = 0;
    case (it.cmd)
      mtel_pkg::CMD_INSERT: begin
        e.at = it.at; e.st = it.status; e.d1 = it.data1; e.d2 = it.data2;
        good = insert_event(it.track, e);
      end
      mtel_pkg::CMD_CLEAR: begin
        clear_track(it.track); good = 1;
      end
      mtel_pkg::CMD_SETLEN: if (it.len != 0) begin
        trk_len[it.track] = it.len; trk_start[it.track] = it.now;
        trk_cursor[it.track] = trk_head[it.track]; good = 1;
      end
      mtel_pkg::CMD_START: begin
        for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++) if (trk_count[t] > 0) good = 1;
        if (good) begin
          is_playing = 1'b1;
          for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++) begin
            trk_start[t] = it.now; trk_cursor[t] = trk_head[t];
          end
        end
      end
      mtel_pkg::CMD_STOP: begin
        for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++) begin
          queue_result(mtel_pkg::KIND_REL, t, '0); trk_cursor[t] = trk_head[t];
        end
        is_playing = 1'b0; good = 1;
      end
      mtel_pkg::CMD_TICK: begin
        if (is_playing) run_tick(it.now);
        good = 1;
      end
      default: good = 0;
    endcase
    queue_result(good ? mtel_pkg::KIND_OK : mtel_pkg::KIND_REJ, 0, '0);
    expected_results[$].last = 1'b1;
  endtask

  // one command transaction
  task automatic send_command(mtel_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_cmd <= it.cmd; in_track <= it.track; in_event_time_us <= it.at;
    in_status <= it.status; in_data1 <= it.data1; in_data2 <= it.data2;
    in_length_us <= it.len; in_now_us <= it.now;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_command(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic mtel_pkg::item_t make_item(mtel_pkg::cmd_t c, int trk,
                                                logic [mtel_pkg::TIME_W-1:0] now);
    mtel_pkg::item_t it;
    it.cmd = c; it.track = trk[1:0]; it.at = $urandom_range(2000);
    it.status = 8'($urandom); it.data1 = 7'($urandom); it.data2 = 7'($urandom);
    it.len = $urandom_range(3000, 500); it.now = now;
    return it;
  endfunction

  task automatic drain_and_settle();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_limit(logic [5:0] v);
    cfg_valid <= 1'b1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random pops, compare each transaction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      mtel_pkg::result_t x;
      results_seen++;
      if (out_kind == mtel_pkg::KIND_PLAY) plays_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d", out_kind);
        fail_count++;
      end else begin
        x = expected_results.pop_front();
        if (out_kind != x.kind) begin
          $error("kind exp %0d got %0d", x.kind, out_kind); fail_count++;
        end
        if (out_track != x.trk) begin
          $error("track exp %0d got %0d", x.trk, out_track); fail_count++;
        end
        if (out_time_us != x.at) begin
          $error("time_us exp %0d got %0d", x.at, out_time_us); fail_count++;
        end
        if (out_status != x.st) begin
          $error("status exp %0h got %0h", x.st, out_status); fail_count++;
        end
        if (out_data1 != x.d1) begin
          $error("data1 exp %0h got %0h", x.d1, out_data1); fail_count++;
        end
        if (out_data2 != x.d2) begin
          $error("data2 exp %0h got %0h", x.d2, out_data2); fail_count++;
        end
        if (out_events_in_use != x.used) begin
          $error("events_in_use exp %0d got %0d", x.used, out_events_in_use); fail_count++;
        end
        if (out_overflows != x.ovf) begin
          $error("overflows exp %0d got %0d", x.ovf, out_overflows); fail_count++;
        end
        if (out_last != x.last) begin
          $error("last exp %0b got %0b", x.last, out_last); fail_count++;
        end
      end
    end
  end

  always @(negedge clk) out_pop <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  logic [mtel_pkg::TIME_W-1:0] clock_now = '0;

  task automatic test_directed();
    mtel_pkg::item_t it;
    it = make_item(mtel_pkg::CMD_TICK, 0, 0); send_command(it);      // tick while stopped
    it = make_item(mtel_pkg::CMD_START, 0, 0); send_command(it);     // start with nothing
    it = make_item(mtel_pkg::cmd_t'(3'd6), 0, 0); send_command(it);  // unknown codes
    it = make_item(mtel_pkg::cmd_t'(3'd7), 3, 0); send_command(it);
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0);
    it.at = 32'hFFFF_FFFF; it.status = 8'hFF; it.data1 = 7'h7F; it.data2 = 7'h7F;
    send_command(it);
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0);
    it.at = 0; it.status = 0; it.data1 = 0; it.data2 = 0;
    send_command(it);
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0); it.at = 100; send_command(it);
    // equal time keeps order
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0); it.at = 100; send_command(it);
    // middle insert
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0); it.at = 50; send_command(it);
    // zero length
    it = make_item(mtel_pkg::CMD_SETLEN, 1, 0); it.len = 0; send_command(it);
    it = make_item(mtel_pkg::CMD_SETLEN, 0, 48'hFFFF_FFFF_FF00); it.len = 32'hFFFF_FFFF;
    send_command(it);
    it = make_item(mtel_pkg::CMD_SETLEN, 0, 48'hFFFF_FFFF_FF00); it.len = 200;
    send_command(it);
    it = make_item(mtel_pkg::CMD_START, 0, 48'hFFFF_FFFF_FF00); send_command(it);
    // modulo wrap of time
    it = make_item(mtel_pkg::CMD_TICK, 0, 48'h0000_0000_0010); send_command(it);
    // behind the cursor
    it = make_item(mtel_pkg::CMD_INSERT, 0, 0); it.at = 1; send_command(it);
    it = make_item(mtel_pkg::CMD_TICK, 0, 48'h0000_0000_0500); send_command(it);
    it = make_item(mtel_pkg::CMD_STOP, 0, 0); send_command(it);
    it = make_item(mtel_pkg::CMD_STOP, 0, 0); send_command(it);      // already stopped
    it = make_item(mtel_pkg::CMD_CLEAR, 0, 0); send_command(it);
    it = make_item(mtel_pkg::CMD_CLEAR, 2, 0); send_command(it);     // empty track
    drain_and_settle();
  endtask

  // sessions: fill, set lengths, start, tick with advancing time amid stray commands
  task automatic test_random_sessions(int n_items);
    mtel_pkg::item_t it;
    int k, c;
    k = 0;
    while (k < n_items) begin
      for (int i = 0; i < 6; i++, k++) begin
        it = make_item(mtel_pkg::CMD_INSERT, $urandom_range(3), 0);
        if ($urandom_range(9) == 0) it.at = $urandom;
        send_command(it);
      end
      for (int t = 0; t < mtel_pkg::TRACK_COUNT; t++, k++) begin
        it = make_item(mtel_pkg::CMD_SETLEN, t, clock_now); send_command(it);
      end
      it = make_item(mtel_pkg::CMD_START, 0, clock_now); send_command(it); k++;
      for (int i = 0; i < 8; i++, k++) begin
        c = $urandom_range(19);
        clock_now += $urandom_range(900);
        if (c == 0) it = make_item(mtel_pkg::CMD_INSERT, $urandom_range(3), clock_now);
        else if (c == 1) it = make_item(mtel_pkg::cmd_t'($urandom_range(7)),
                                        $urandom_range(3), {16'd0, $urandom});
        else it = make_item(mtel_pkg::CMD_TICK, 0, clock_now);
        if (c == 1) it.len = $urandom;
        send_command(it);
      end
      if ($urandom_range(3) == 0) begin
        it = make_item(mtel_pkg::CMD_STOP, 0, clock_now); send_command(it); k++;
      end
      if ($urandom_range(2) == 0) begin
        it = make_item(mtel_pkg::CMD_CLEAR, $urandom_range(3), 0); send_command(it); k++;
      end
    end
  endtask

  initial begin
    reset_mirror();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33; recv_idle_pct = 57;
    test_directed();
    write_limit(6'd1);
    test_random_sessions(35);
    drain_and_settle();
    write_limit(6'd63);
    send_idle_pct = 57; recv_idle_pct = 33;
    test_random_sessions(35);
    drain_and_settle();
    write_limit(6'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_sessions(15);
    drain_and_settle();
    write_limit(6'd56);
    test_random_sessions(15);
    drain_and_settle();
    $display("covered %0d commands, %0d result transactions, %0d play events",
             items_sent, results_seen, plays_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: multitrack_event_loop_store.f
design/mtel_pkg.sv
design/mtel_cmd_q.sv
design/mtel_res_q.sv
design/mtel_div.sv
design/mtel_engine.sv
design/multitrack_event_loop_store.sv
tb/tb_multitrack_event_loop_store.sv
